// ===== sv/ccd_pkg.sv =====
// Package with constants and types shared by the command deframer.
package ccd_pkg;

    localparam int SectorBytes     = 512;
    localparam int MaxPayloadBytes = 516;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;

    typedef enum logic [3:0] {
        K_BAD_LEN   = 4'd0,
        K_CRC_NAK   = 4'd1,
        K_SYNC_ACK  = 4'd2,
        K_WR_WORD   = 4'd3,
        K_WR_NAK    = 4'd4,
        K_DONE_REQ  = 4'd5,
        K_DONE_NAK  = 4'd6,
        K_BOOT_REQ  = 4'd7,
        K_BOOT_NAK  = 4'd8,
        K_UNK_NAK   = 4'd9
    } t_kind;

    localparam logic [2:0] RegSync   = 3'd0;
    localparam logic [2:0] RegWrite  = 3'd1;
    localparam logic [2:0] RegDone   = 3'd2;
    localparam logic [2:0] RegReboot = 3'd3;
    localparam logic [2:0] RegRegion = 3'd4;
    localparam logic [2:0] RegTmo    = 3'd5;

endpackage

// ===== sv/ccd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ccd_ram #(
    parameter int Width = 8,
    parameter int Depth = 516
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/crc16_checked_command_deframer.sv =====
// Command frame deframer with CRC16-CCITT-FALSE check.
// Header and payload bytes are folded into the CRC one bit per cycle, so the next byte
// is not taken until all eight bits are folded; lead bytes, CRC bytes and ticks need no shift.
// A checked frame reads back its first eight payload bytes, then gives a single result (a
// CRC nak comes straight from the last CRC byte); a write instead gives one word per 8 bytes read.
// Synchronous active-low reset returns to idle; the payload RAM is not cleared.
module crc16_checked_command_deframer #(
    parameter int SECTOR_BYTES      = ccd_pkg::SectorBytes,
    parameter int MAX_PAYLOAD_BYTES = ccd_pkg::MaxPayloadBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_kind,
    output logic [23:0] o_byte_address,
    output logic [63:0] o_data_word,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ccd_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD_BYTES);
    localparam int NWords = SECTOR_BYTES / 8;
    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD_BYTES);
    localparam logic [15:0] WrLen  = 16'(SECTOR_BYTES + 4);
    localparam int SB = $clog2(SECTOR_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_HDR, S_PAY, S_CRCLO, S_CRCHI, S_SHIFT,
        S_RD, S_DISP, S_WORD, S_OUT
    } t_state;

    // Configuration registers.
    logic [7:0]  r_code_sync, r_code_write, r_code_done, r_code_reboot;
    logic [24:0] r_region;
    logic [15:0] r_tmo;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[4:2])
            RegSync:   prdata = {24'd0, r_code_sync};
            RegWrite:  prdata = {24'd0, r_code_write};
            RegDone:   prdata = {24'd0, r_code_done};
            RegReboot: prdata = {24'd0, r_code_reboot};
            RegRegion: prdata = {7'd0, r_region};
            RegTmo:    prdata = {16'd0, r_tmo};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_sync   <= 8'd1;
            r_code_write  <= 8'd2;
            r_code_done   <= 8'd3;
            r_code_reboot <= 8'd4;
            r_region      <= 25'd65536;
            r_tmo         <= 16'd1000;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                RegSync:   r_code_sync   <= pwdata[7:0];
                RegWrite:  r_code_write  <= pwdata[7:0];
                RegDone:   r_code_done   <= pwdata[7:0];
                RegReboot: r_code_reboot <= pwdata[7:0];
                RegRegion: r_region      <= pwdata[24:0];
                RegTmo:    r_tmo         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    t_state      r_state;
    t_state      r_ret;
    logic [1:0]  r_hidx;
    logic [AW:0] r_idx;
    logic [7:0]  r_cmd;
    logic [15:0] r_len;
    logic [15:0] r_crc;
    logic [15:0] r_rcrc;
    logic [15:0] r_quiet;
    logic [7:0]  r_sh;
    logic [3:0]  r_bit;
    logic [AW:0] r_raddr;
    logic [3:0]  r_nb;
    logic [63:0] r_acc;
    logic [23:0] r_addr;
    logic [$clog2(NWords+1)-1:0] r_words;
    logic        r_ovalid;
    logic [3:0]  r_okind;
    logic [23:0] r_oaddr;
    logic [63:0] r_odata;
    logic        r_olast;
    logic        r_rd_wait;

    logic [7:0]  w_rdata;
    logic        w_we;
    logic [AW-1:0] w_rd_a;

    assign w_we   = (r_state == S_PAY) && i_valid && o_ready && !i_action
                    && (r_idx < (AW+1)'(MAX_PAYLOAD_BYTES));
    assign w_rd_a = r_raddr[AW-1:0];

    ccd_ram #(.Width(8), .Depth(MAX_PAYLOAD_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (w_rd_a),
        .o_rdata (w_rdata)
    );

    // Input is taken only in frame-reception states with the output free.
    assign o_ready = !r_ovalid && (r_state == S_IDLE || r_state == S_HDR ||
                     r_state == S_PAY || r_state == S_CRCLO || r_state == S_CRCHI);

    assign o_valid        = r_ovalid;
    assign o_kind         = r_okind;
    assign o_byte_address = r_oaddr;
    assign o_data_word    = r_odata;
    assign o_last         = r_olast;

    logic        w_fb;
    logic [15:0] w_crc_step;
    logic        w_acc;
    logic [24:0] w_off_end;
    logic        w_wr_ok;
    logic        w_done_ok;

    assign w_acc      = i_valid && o_ready;
    assign w_fb       = r_crc[15] ^ r_sh[7];
    assign w_crc_step = {r_crc[14:0], 1'b0} ^ (w_fb ? CrcPoly : 16'd0);
    assign w_off_end  = {1'b0, r_acc[23:0]} + 25'(SECTOR_BYTES);
    assign w_wr_ok    = (r_len == WrLen) && (r_acc[SB-1:0] == '0) && (r_acc[31:24] == 8'd0)
                        && (w_off_end <= r_region);
    assign w_done_ok  = (r_len == 16'd8) && (r_acc[31:0] != 32'd0) && (r_acc[SB-1:0] == '0)
                        && (r_acc[31:25] == 7'd0) && (r_acc[24:0] <= r_region);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_hidx     <= 2'd0;
            r_idx      <= '0;
            r_cmd      <= 8'd0;
            r_len      <= 16'd0;
            r_crc      <= CrcInit;
            r_rcrc     <= 16'd0;
            r_quiet    <= 16'd0;
            r_ovalid   <= 1'b0;
            r_bit      <= 4'd0;
            r_words    <= '0;
            r_rd_wait  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && !i_action) begin
                        r_state <= S_HDR;
                        r_hidx  <= 2'd0;
                        r_crc   <= CrcInit;
                        r_rcrc  <= 16'd0;
                        r_quiet <= 16'd0;
                    end
                end
                S_HDR, S_PAY, S_CRCLO, S_CRCHI: begin
                    if (w_acc && i_action) begin
                        if ((r_quiet == 16'hFFFF ? r_quiet : r_quiet + 16'd1) >= r_tmo)
                        begin
                            r_state <= S_IDLE;
                            r_quiet <= 16'd0;
                        end else if (r_quiet != 16'hFFFF) begin
                            r_quiet <= r_quiet + 16'd1;
                        end
                    end else if (w_acc) begin
                        r_quiet <= 16'd0;
                        case (r_state)
                            S_HDR: begin
                                r_sh  <= i_rx_byte;
                                r_bit <= 4'd0;
                                r_ret <= S_HDR;
                                r_state <= S_SHIFT;
                                if (r_hidx == 2'd0) begin
                                    r_cmd <= i_rx_byte;
                                end else if (r_hidx == 2'd1) begin
                                    r_len <= {8'd0, i_rx_byte};
                                end else begin
                                    r_len <= {i_rx_byte, r_len[7:0]};
                                end
                            end
                            S_PAY: begin
                                r_sh  <= i_rx_byte;
                                r_bit <= 4'd0;
                                r_ret <= S_PAY;
                                r_state <= S_SHIFT;
                                r_idx <= r_idx + 1'b1;
                            end
                            S_CRCLO: begin
                                r_rcrc  <= {8'd0, i_rx_byte};
                                r_state <= S_CRCHI;
                            end
                            default: begin
                                r_rcrc <= {i_rx_byte, r_rcrc[7:0]};
                                if ({i_rx_byte, r_rcrc[7:0]} != r_crc) begin
                                    r_state  <= S_IDLE;
                                    r_ovalid <= 1'b1;
                                    r_okind  <= K_CRC_NAK;
                                    r_oaddr  <= 24'd0;
                                    r_odata  <= 64'd0;
                                    r_olast  <= 1'b1;
                                end else begin
                                    r_raddr <= '0;
                                    r_nb    <= 4'd0;
                                    r_acc   <= 64'd0;
                                    r_rd_wait <= 1'b1;
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // One CRC bit per cycle, MSB first.
                    r_crc <= w_crc_step;
                    r_sh  <= {r_sh[6:0], 1'b0};
                    r_bit <= r_bit + 4'd1;
                    if (r_bit == 4'd7) begin
                        if (r_ret == S_HDR) begin
                            if (r_hidx == 2'd2) begin
                                r_idx  <= '0;
                                r_hidx <= 2'd0;
                                if (r_len > MaxLen) begin
                                    r_state  <= S_IDLE;
                                    r_ovalid <= 1'b1;
                                    r_okind  <= K_BAD_LEN;
                                    r_oaddr  <= 24'd0;
                                    r_odata  <= 64'd0;
                                    r_olast  <= 1'b1;
                                end else begin
                                    r_state <= (r_len == 16'd0) ? S_CRCLO : S_PAY;
                                end
                            end else begin
                                r_hidx  <= r_hidx + 2'd1;
                                r_state <= S_HDR;
                            end
                        end else begin
                            r_state <= ({{(15-AW){1'b0}}, r_idx} >= r_len) ? S_CRCLO : S_PAY;
                        end
                    end
                end
                S_RD: begin
                    // Read the first eight payload bytes a byte per cycle.
                    if (r_rd_wait) begin
                        r_rd_wait <= 1'b0;
                        r_raddr   <= r_raddr + 1'b1;
                    end else begin
                        r_acc <= {w_rdata, r_acc[63:8]};
                        r_nb  <= r_nb + 4'd1;
                        r_raddr <= r_raddr + 1'b1;
                        if (r_nb == 4'd7) begin
                            r_state <= S_DISP;
                        end
                    end
                end
                S_DISP: begin
                    if (r_cmd != r_code_sync && r_cmd == r_code_write && w_wr_ok) begin
                        r_addr    <= r_acc[23:0];
                        r_words   <= '0;
                        r_raddr   <= (AW+1)'(4);
                        r_nb      <= 4'd0;
                        r_rd_wait <= 1'b1;
                        r_state   <= S_WORD;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                        if (r_cmd == r_code_sync) begin
                            r_okind <= K_SYNC_ACK;
                            r_oaddr <= 24'd0;
                            r_odata <= 64'd0;
                        end else if (r_cmd == r_code_write) begin
                            r_okind <= K_WR_NAK;
                            r_oaddr <= 24'd0;
                            r_odata <= 64'd0;
                        end else if (r_cmd == r_code_done && w_done_ok) begin
                            r_okind <= K_DONE_REQ;
                            r_oaddr <= r_acc[23:0];
                            r_odata <= {32'd0, r_acc[63:32]};
                        end else if (r_cmd == r_code_done) begin
                            r_okind <= K_DONE_NAK;
                            r_oaddr <= 24'd0;
                            r_odata <= 64'd0;
                        end else if (r_cmd == r_code_reboot) begin
                            r_okind <= (r_len == 16'd0) ? K_BOOT_REQ : K_BOOT_NAK;
                            r_oaddr <= 24'd0;
                            r_odata <= 64'd0;
                        end else begin
                            r_okind <= K_UNK_NAK;
                            r_oaddr <= 24'd0;
                            r_odata <= 64'd0;
                        end
                    end
                end
                S_WORD: begin
                    if (r_rd_wait) begin
                        r_rd_wait <= 1'b0;
                        r_raddr   <= r_raddr + 1'b1;
                    end else begin
                        r_acc   <= {w_rdata, r_acc[63:8]};
                        r_nb    <= r_nb + 4'd1;
                        r_raddr <= r_raddr + 1'b1;
                        if (r_nb == 4'd7) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                default: begin
                    // S_OUT: present one word once the output register is free.
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= K_WR_WORD;
                        r_oaddr  <= r_addr;
                        r_odata  <= r_acc;
                        r_olast  <= (r_words == ($bits(r_words))'(NWords - 1));
                        r_addr   <= r_addr + 24'd8;
                        r_words  <= r_words + 1'b1;
                        r_nb     <= 4'd0;
                        r_raddr  <= r_raddr - 1'b1;
                        r_rd_wait <= 1'b1;
                        r_state  <= (r_words == ($bits(r_words))'(NWords - 1)) ? S_IDLE
                                                                              : S_WORD;
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> !o_ready)
        else $error("input accepted during CRC shift");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind) && $stable(o_data_word)))
        else $error("result changed while stalled");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_bit <= 4'd7))
        else $error("CRC bit counter out of range");
`endif

endmodule

// ===== verif/crc16_checked_command_deframer_tb.sv =====
// Self-checking testbench for the CRC16 command frame deframer.
`timescale 1ns / 1ps

module crc16_checked_command_deframer_tb;
    import ccd_pkg::*;

    localparam int SECTOR = SectorBytes;
    localparam int MAXPL  = MaxPayloadBytes;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] addr;
        logic [63:0] data;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_kind;
    logic [23:0] o_byte_address;
    logic [63:0] o_data_word;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int     mismatches = 0;
    longint cycles = 0;
    bit     rx_stall_free = 0;

    crc16_checked_command_deframer i_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Predicts deframer results from accepted transfers and checks outputs.
    class FrameScoreboard;
        logic [7:0]  sync_code = 8'd1, write_code = 8'd2, done_code = 8'd3, boot_code = 8'd4;
        logic [24:0] region = 25'd65536;
        logic [15:0] tmo = 16'd1000;
        int          phase = 0;  // 0 idle, 1 header, 2 payload, 3 crc low, 4 crc high
        int          idx = 0;
        logic [7:0]  cmd = 0;
        logic [15:0] plen = 0, crc_run = CrcInit, crc_rx = 0, quiet = 0;
        logic [7:0]  pbuf [MAXPL];
        t_result     pending[$];

        function void set_reg(int r, logic [31:0] v);
            case (r)
                RegSync:   sync_code  = v[7:0];
                RegWrite:  write_code = v[7:0];
                RegDone:   done_code  = v[7:0];
                RegReboot: boot_code  = v[7:0];
                RegRegion: region     = v[24:0];
                RegTmo:    tmo        = v[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            c = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
            return c;
        endfunction

        function logic [63:0] le(int at, int n);
            logic [63:0] v = 0;
            for (int k = 0; k < n; k++)
                if (at + k < MAXPL) v |= 64'(pbuf[at + k]) << (8 * k);
            return v;
        endfunction

        function void push(t_kind k, logic [23:0] a, logic [63:0] d, logic l);
            t_result r;
            r.kind = k; r.addr = a; r.data = d; r.last = l;
            pending.push_back(r);
        endfunction

        function void finish_frame();
            logic [63:0] off, sz;
            if (crc_rx != crc_run) push(K_CRC_NAK, 0, 0, 1);
            else if (cmd == sync_code) push(K_SYNC_ACK, 0, 0, 1);
            else if (cmd == write_code) begin
                off = le(0, 4);
                if (plen != 16'(4 + SECTOR) || off % SECTOR != 0 || off + SECTOR > region)
                    push(K_WR_NAK, 0, 0, 1);
                else
                    for (int w = 0; w < SECTOR / 8; w++)
                        push(K_WR_WORD, 24'(off + 8 * w), le(4 + 8 * w, 8), w == SECTOR / 8 - 1);
            end else if (cmd == done_code) begin
                sz = le(0, 4);
                if (plen != 8 || sz == 0 || sz % SECTOR != 0 || sz > region)
                    push(K_DONE_NAK, 0, 0, 1);
                else push(K_DONE_REQ, sz[23:0], le(4, 4), 1);
            end else if (cmd == boot_code) push(plen == 0 ? K_BOOT_REQ : K_BOOT_NAK, 0, 0, 1);
            else push(K_UNK_NAK, 0, 0, 1);
        endfunction

        function void note_input(logic act, logic [7:0] b);
            if (act) begin
                if (phase == 0) return;
                if (quiet != 16'hFFFF) quiet++;
                if (quiet >= tmo) begin phase = 0; quiet = 0; end
                return;
            end
            quiet = 0;
            case (phase)
                0: begin phase = 1; idx = 0; crc_run = CrcInit; crc_rx = 0; end
                1: begin
                    crc_run = crc_byte(crc_run, b);
                    if (idx == 0) begin cmd = b; idx = 1; end
                    else if (idx == 1) begin plen = {8'd0, b}; idx = 2; end
                    else begin
                        plen[15:8] = b; idx = 0;
                        if (plen > MAXPL) begin phase = 0; push(K_BAD_LEN, 0, 0, 1); end
                        else phase = plen == 0 ? 3 : 2;
                    end
                end
                2: begin
                    crc_run = crc_byte(crc_run, b);
                    if (idx < MAXPL) pbuf[idx] = b;
                    idx++;
                    if (idx >= plen) phase = 3;
                end
                3: begin crc_rx = {8'd0, b}; phase = 4; end
                default: begin crc_rx[15:8] = b; phase = 0; finish_frame(); end
            endcase
        endfunction

        task check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            e = pending.pop_front();
            if (got.kind !== e.kind) report($sformatf("kind %0d exp %0d", got.kind, e.kind));
            if (got.addr !== e.addr) report($sformatf("addr %h exp %h", got.addr, e.addr));
            if (got.data !== e.data) report($sformatf("data %h exp %h", got.data, e.data));
            if (got.last !== e.last) report($sformatf("last %b exp %b", got.last, e.last));
        endtask
    endclass

    FrameScoreboard sb = new();

    always @(posedge i_clk) begin
        t_result r;
        cycles++;
        if (i_rst_n && i_valid && o_ready) sb.note_input(i_action, i_rx_byte);
        if (i_rst_n && o_valid && i_ready) begin
            r.kind = t_kind'(o_kind); r.addr = o_byte_address;
            r.data = o_data_word; r.last = o_last;
            sb.check_result(r);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver side stalls about 31 percent of the time except in a quiet stretch.
    always @(negedge i_clk)
        i_ready <= rx_stall_free ? 1'b1 : ($urandom_range(99) >= 31);

    // Valid stays high after the accepting edge until the next falling edge decides.
    task automatic send(input logic act, input logic [7:0] b);
        @(negedge i_clk);
        while (!rx_stall_free && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1; i_action <= act; i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] r, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(r, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
    endtask

    // Sends a complete frame; a nonzero crc_flip corrupts the trailing CRC.
    task automatic send_frame(input logic [7:0] c, input logic [7:0] pl[$],
                              input logic [15:0] crc_flip);
        logic [15:0] crc;
        logic [15:0] n;
        crc = CrcInit;
        n = 16'(pl.size());
        send(1'b0, 8'($urandom_range(255)));
        send(1'b0, c);        crc = sb.crc_byte(crc, c);
        send(1'b0, n[7:0]);   crc = sb.crc_byte(crc, n[7:0]);
        send(1'b0, n[15:8]);  crc = sb.crc_byte(crc, n[15:8]);
        foreach (pl[k]) begin
            send(1'b0, pl[k]); crc = sb.crc_byte(crc, pl[k]);
        end
        crc ^= crc_flip;
        send(1'b0, crc[7:0]);
        send(1'b0, crc[15:8]);
    endtask

    function automatic void put_le(ref logic [7:0] pl[$], input logic [31:0] v);
        for (int k = 0; k < 4; k++) pl.push_back(v[8 * k +: 8]);
    endfunction

    task automatic random_frame();
        logic [7:0] pl[$];
        int sel, n;
        logic [7:0] c;
        n = 0;
        sel = $urandom_range(9);
        case (sel)
            0, 1: begin  // short writes, refused for their length; a full sector is directed
                c = sb.write_code;
                put_le(pl, $urandom_range(3) != 0 ?
                       SECTOR * $urandom_range(sb.region / SECTOR + 1) : $urandom);
                n = $urandom_range(6);
            end
            2, 3: begin
                c = sb.done_code;
                put_le(pl, $urandom_range(3) != 0 ?
                       SECTOR * $urandom_range(sb.region / SECTOR + 1) : $urandom);
                put_le(pl, $urandom);
                n = ($urandom_range(6) == 0) ? 1 : 0;
            end
            4: begin c = sb.boot_code; n = $urandom_range(1) ? 0 : $urandom_range(1, 5); end
            5: begin c = sb.sync_code; n = $urandom_range(6); end
            default: begin c = 8'($urandom_range(255)); n = $urandom_range(8); end
        endcase
        for (int k = 0; k < n; k++) pl.push_back(8'($urandom_range(255)));
        send_frame(c, pl, $urandom_range(7) == 0 ? 16'($urandom_range(1, 65535)) : 16'd0);
    endtask

    initial begin
        logic [7:0] pl[$];
        int sent;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: each command, extremes, CRC error, bad length, timeout, idle ticks.
        send(1'b1, 8'hFF);
        send_frame(8'd1, pl, 16'd0);
        pl = {}; send_frame(8'd1, pl, 16'h0001);
        pl = {}; send_frame(8'd4, pl, 16'd0);
        pl = '{8'hFF}; send_frame(8'd4, pl, 16'd0);
        pl = {}; put_le(pl, 32'd65536 - SECTOR);
        for (int k = 0; k < SECTOR; k++) pl.push_back(k[0] ? 8'hFF : 8'h00);
        send_frame(8'd2, pl, 16'd0);
        pl = {}; put_le(pl, 32'd65536); put_le(pl, 32'hFFFFFFFF); send_frame(8'd3, pl, 16'd0);
        pl = {}; put_le(pl, 32'd512); put_le(pl, 32'h12345678); send_frame(8'd3, pl, 16'd0);
        pl = {}; put_le(pl, 32'd0); put_le(pl, 32'd0); send_frame(8'd3, pl, 16'd0);
        pl = {}; send_frame(8'hFF, pl, 16'd0);
        pl = {}; send_frame(8'h00, pl, 16'd0);
        send(1'b0, 8'h00); send(1'b0, 8'h01); send(1'b0, 8'hFF); send(1'b0, 8'hFF);  // bad length
        drain();

        reg_write(RegTmo, 32'd1);
        send(1'b0, 8'hAA); send(1'b0, 8'h01); send(1'b1, 8'd0);  // dropped by timeout
        pl = {}; send_frame(8'd1, pl, 16'd0);
        drain();

        // Equal codes and the largest region.
        reg_write(RegSync, 32'hFF); reg_write(RegWrite, 32'hFF);
        reg_write(RegDone, 32'h00); reg_write(RegReboot, 32'h00);
        reg_write(RegRegion, 32'h1000000); reg_write(RegTmo, 32'hFFFF);
        pl = {}; send_frame(8'hFF, pl, 16'd0);
        pl = {}; put_le(pl, 32'h1000000); put_le(pl, 32'hCAFEF00D); send_frame(8'h00, pl, 16'd0);
        drain();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin reg_write(RegSync, 1); reg_write(RegWrite, 2); reg_write(RegDone, 3);
                          reg_write(RegReboot, 4); reg_write(RegRegion, 4096);
                          reg_write(RegTmo, 3); end
                1: begin reg_write(RegRegion, 0); reg_write(RegTmo, 1000); end
                2: begin reg_write(RegSync, $urandom_range(255));
                          reg_write(RegWrite, $urandom_range(255));
                          reg_write(RegDone, $urandom_range(255));
                          reg_write(RegReboot, $urandom_range(255));
                          reg_write(RegRegion, 32'h1FFFFFF & 32'h1000000);
                          reg_write(RegTmo, 2); end
                default: rx_stall_free = 1;
            endcase
            for (int f = 0; f < 3; f++) begin
                random_frame();
                // Noise: stray ticks, which may time out a partial frame.
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 4)) send(1'b1, 8'($urandom_range(255)));
                if ($urandom_range(5) == 0) begin
                    send(1'b0, 8'($urandom_range(255))); send(1'b0, 8'($urandom_range(255)));
                    repeat (4) send(1'b1, 8'd0);
                end
            end
            drain();
            rx_stall_free = 0;
        end

        drain();
        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/ccd_pkg.sv
sv/ccd_ram.sv
sv/crc16_checked_command_deframer.sv
verif/crc16_checked_command_deframer_tb.sv
